>>> hdl/tasp_pkg.sv
// Shared types and constants for the three-axis step pulse generator.
// Holds fixed field widths, multiplier constants, register indexes and the
// sequencer and lane interface types. Depends on nothing.
package tasp_pkg;

    localparam int MAX_AXES            = 3;
    localparam int DEF_NUM_AXES        = 3;
    localparam int DEF_STEP_COUNT_BITS = 24;
    localparam int DEF_PERIOD_BITS     = 40;

    localparam int TICK_W    = 16;
    localparam int MULT_W    = 17;
    localparam int MULT_FRAC = 16;
    localparam int DT_BITS   = TICK_W + MULT_W;
    localparam int AXIS_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [MULT_W-1:0] MULT_ONE   = 17'd65536;
    localparam logic [MULT_W-1:0] MULT_FLOOR = 17'd3277;
    localparam logic [TICK_W-1:0] TICK_RESET = 16'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INC    = 2'd2;

    localparam logic CMD_LOAD = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MUL,
        PH_ADD,
        PH_CMP,
        PH_MERGE
    } t_phase;

    typedef struct packed {
        logic add_en;
        logic cmp_en;
        logic commit_tick;
        logic commit_load;
    } t_lane_ctl;

    typedef struct packed {
        logic pulse;
        logic below_decel;
        logic busy_next;
        logic load_busy;
    } t_lane_stat;

endpackage

>>> hdl/tasp_lane.sv
// One axis lane: step count, period and phase accumulator of a single axis.
// Two working steps per tick (accumulate, then compare and subtract).
// Depends on tasp_pkg.
module tasp_lane
    import tasp_pkg::*;
#(
    parameter int STEP_COUNT_BITS = DEF_STEP_COUNT_BITS,
    parameter int PERIOD_BITS     = DEF_PERIOD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_lane_ctl                  i_ctl,
    input  logic [DT_BITS-1:0]         i_dt,
    input  logic [STEP_COUNT_BITS-1:0] i_decel,
    input  logic [STEP_COUNT_BITS-1:0] i_load_steps,
    input  logic [PERIOD_BITS-1:0]     i_load_period,
    output t_lane_stat                 o_stat
);

    localparam int SUM_W = ((PERIOD_BITS > DT_BITS) ? PERIOD_BITS : DT_BITS) + 1;

    logic [STEP_COUNT_BITS-1:0] r_rem;
    logic [PERIOD_BITS-1:0]     r_acc;
    logic [PERIOD_BITS-1:0]     r_period;
    logic [PERIOD_BITS-1:0]     r_sum;
    logic [PERIOD_BITS-1:0]     r_pend_acc;
    logic [STEP_COUNT_BITS-1:0] r_pend_rem;
    logic                       r_pend_pulse;

    logic [SUM_W-1:0]       sum_full;
    logic [PERIOD_BITS-1:0] n_sum;
    logic [PERIOD_BITS:0]   diff;
    logic                   rem_nz;
    logic                   reached;

    // Accumulate with saturation at the full-scale period value.
    always_comb begin
        sum_full = SUM_W'(r_acc) + SUM_W'(i_dt);
        if (sum_full[SUM_W-1:PERIOD_BITS] != '0) begin
            n_sum = '1;
        end else begin
            n_sum = sum_full[PERIOD_BITS-1:0];
        end
    end

    assign diff    = {1'b0, r_sum} - {1'b0, r_period};
    assign rem_nz  = (r_rem != '0);
    assign reached = rem_nz && !diff[PERIOD_BITS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.add_en) begin
            r_sum <= n_sum;
        end
        if (i_ctl.cmp_en) begin
            r_pend_acc <= !rem_nz ? r_acc : (reached ? diff[PERIOD_BITS-1:0] : r_sum);
            r_pend_rem <= reached ? r_rem - STEP_COUNT_BITS'(1) : r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem        <= '0;
            r_acc        <= '0;
            r_period     <= '0;
            r_pend_pulse <= 1'b0;
        end else begin
            if (i_ctl.cmp_en) begin
                r_pend_pulse <= reached;
            end
            if (i_ctl.commit_load) begin
                r_rem    <= i_load_steps;
                r_period <= i_load_period;
                r_acc    <= '0;
            end else if (i_ctl.commit_tick) begin
                r_rem <= r_pend_rem;
                r_acc <= r_pend_acc;
            end
        end
    end

    assign o_stat.pulse       = r_pend_pulse;
    assign o_stat.below_decel = (r_pend_rem < i_decel);
    assign o_stat.busy_next   = (r_pend_rem != '0);
    assign o_stat.load_busy   = (i_load_steps != '0);

endmodule

>>> hdl/tasp_merge.sv
// Merging stage: combines the lane results into one result beat, runs the
// speed ramp and holds the move-wide state and the output register.
// Depends on tasp_pkg.
module tasp_merge
    import tasp_pkg::*;
#(
    parameter int NUM_AXES        = DEF_NUM_AXES,
    parameter int STEP_COUNT_BITS = DEF_STEP_COUNT_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_lane_ctl                  i_ctl,
    input  t_lane_stat [MAX_AXES-1:0]  i_stat,
    input  logic                       i_ramp_enable,
    input  logic [MULT_W-1:0]          i_ramp_inc,
    input  logic [MAX_AXES-1:0]        i_load_dirs,
    input  logic [STEP_COUNT_BITS-1:0] i_load_decel,
    input  logic [MULT_W-1:0]          i_load_mult,
    input  logic [AXIS_W-1:0]          i_load_axis,
    input  logic                       i_out_ready,
    output logic [MULT_W-1:0]          o_mult,
    output logic [STEP_COUNT_BITS-1:0] o_decel,
    output logic                       o_out_valid,
    output logic [MAX_AXES-1:0]        o_step_pulses,
    output logic [MAX_AXES-1:0]        o_dir_out,
    output logic                       o_busy_res,
    output logic [MULT_W-1:0]          o_multiplier_now
);

    localparam logic [MAX_AXES-1:0] DIR_MASK = MAX_AXES'((1 << NUM_AXES) - 1);

    logic [MULT_W-1:0]          r_mult;
    logic [MAX_AXES-1:0]        r_dirs;
    logic [STEP_COUNT_BITS-1:0] r_decel;
    logic [AXIS_W-1:0]          r_axis;
    logic                       r_out_valid;

    logic [MULT_W-1:0]   n_mult;
    logic [MAX_AXES-1:0] n_dirs;
    logic [MAX_AXES-1:0] pulses;
    logic                lead_step;
    logic                lead_below;
    logic                busy_tick;
    logic                busy_load;
    logic [MULT_W:0]     dec_limit;
    logic [MULT_W:0]     inc_sum;
    logic [MULT_W-1:0]   ramped;

    always_comb begin
        lead_step  = 1'b0;
        lead_below = 1'b0;
        busy_tick  = 1'b0;
        busy_load  = 1'b0;
        for (int a = 0; a < MAX_AXES; a++) begin
            pulses[a] = i_stat[a].pulse;
            busy_tick = busy_tick | i_stat[a].busy_next;
            busy_load = busy_load | i_stat[a].load_busy;
            if (r_axis == AXIS_W'(a)) begin
                lead_step  = i_stat[a].pulse;
                lead_below = i_stat[a].below_decel;
            end
        end
    end

    // Ramp step: slow down toward the floor inside the deceleration zone,
    // otherwise speed up toward full speed.
    always_comb begin
        dec_limit = {1'b0, i_ramp_inc} + {1'b0, MULT_FLOOR};
        inc_sum   = {1'b0, r_mult} + {1'b0, i_ramp_inc};
        if (lead_below) begin
            if ({1'b0, r_mult} < dec_limit) begin
                ramped = MULT_FLOOR;
            end else begin
                ramped = r_mult - i_ramp_inc;
            end
        end else if (r_mult < MULT_ONE) begin
            ramped = (inc_sum > {1'b0, MULT_ONE}) ? MULT_ONE : inc_sum[MULT_W-1:0];
        end else begin
            ramped = r_mult;
        end
    end

    always_comb begin
        n_mult = r_mult;
        n_dirs = r_dirs;
        if (i_ctl.commit_load) begin
            n_mult = (i_load_mult > MULT_ONE) ? MULT_ONE : i_load_mult;
            n_dirs = i_load_dirs & DIR_MASK;
        end else if (i_ctl.commit_tick && i_ramp_enable && lead_step) begin
            n_mult = ramped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult      <= MULT_ONE;
            r_dirs      <= '0;
            r_decel     <= '0;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mult <= n_mult;
            r_dirs <= n_dirs;
            if (i_ctl.commit_load) begin
                r_decel <= i_load_decel;
                r_axis  <= i_load_axis;
            end
            if (i_ctl.commit_tick || i_ctl.commit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit_tick || i_ctl.commit_load) begin
            o_step_pulses    <= i_ctl.commit_load ? '0 : pulses;
            o_dir_out        <= n_dirs;
            o_busy_res       <= i_ctl.commit_load ? busy_load : busy_tick;
            o_multiplier_now <= n_mult;
        end
    end

    assign o_mult      = r_mult;
    assign o_decel     = r_decel;
    assign o_out_valid = r_out_valid;

    a_mult_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mult <= MULT_ONE)
        else $error("speed multiplier above 1.0");

    a_mult_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.commit_tick && (pulses == '0)) |=> $stable(r_mult))
        else $error("multiplier changed on a tick without a step");

endmodule

>>> hdl/three_axis_step_pulse_generator.sv
// Top level of the three-axis step pulse generator with speed ramp.
// Holds the input beat register, configuration registers, tick multiplier
// and sequencer. Depends on tasp_pkg, tasp_lane and tasp_merge.
//
// A load beat (command 1) starts a new move at once, replacing any move in
// progress and clearing the phase accumulators; a tick beat (command 0)
// advances every axis that still has steps by one tick time, scaled by the
// speed multiplier when ramping is enabled, and reports which axes stepped.
// Every input beat yields exactly one result beat. Each beat passes through
// four steps of work: forming the tick delta in the tick-time by multiplier
// product, the per-axis accumulator add, the per-axis period compare and
// subtract, and the merging stage that commits the new state and the speed
// ramp. The four steps form a loop through the axis state, so a new beat
// enters only as the previous one commits and the block never works on two
// beats at once. The finished result sits in an output register, so the next
// input beat is taken while a result still waits to be taken; the merge step
// waits only when that register is still full. The axes run as parallel
// lanes. Configuration writes take effect at once and are meant for idle
// periods; no clearing pass is needed after reset.
module three_axis_step_pulse_generator
    import tasp_pkg::*;
#(
    parameter int NUM_AXES        = DEF_NUM_AXES,
    parameter int STEP_COUNT_BITS = DEF_STEP_COUNT_BITS,
    parameter int PERIOD_BITS     = DEF_PERIOD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration write port.
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    // Input channel.
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_command,
    input  logic [STEP_COUNT_BITS-1:0] i_steps_x,
    input  logic [STEP_COUNT_BITS-1:0] i_steps_y,
    input  logic [STEP_COUNT_BITS-1:0] i_steps_z,
    input  logic [PERIOD_BITS-1:0]     i_period_x,
    input  logic [PERIOD_BITS-1:0]     i_period_y,
    input  logic [PERIOD_BITS-1:0]     i_period_z,
    input  logic [MAX_AXES-1:0]        i_move_dirs,
    input  logic [STEP_COUNT_BITS-1:0] i_decel_steps,
    input  logic [MULT_W-1:0]          i_start_multiplier,
    input  logic [AXIS_W-1:0]          i_lead_axis,
    // Output channel.
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [MAX_AXES-1:0]        o_step_pulses,
    output logic [MAX_AXES-1:0]        o_dir_out,
    output logic                       o_busy_res,
    output logic [MULT_W-1:0]          o_multiplier_now
);

    // Configuration registers.
    logic [TICK_W-1:0] r_tick_time;
    logic              r_ramp_enable;
    logic [MULT_W-1:0] r_ramp_inc;

    // Input beat register, held until the beat commits.
    logic                       r_cmd;
    logic [STEP_COUNT_BITS-1:0] r_steps [MAX_AXES];
    logic [PERIOD_BITS-1:0]     r_period [MAX_AXES];
    logic [MAX_AXES-1:0]        r_dirs;
    logic [STEP_COUNT_BITS-1:0] r_decel_in;
    logic [MULT_W-1:0]          r_mult_in;
    logic [AXIS_W-1:0]          r_axis_in;

    logic [DT_BITS-1:0] r_dt;
    t_phase             r_phase;
    t_phase             n_phase;

    t_lane_ctl                  ctl;
    t_lane_stat [MAX_AXES-1:0]  stat;
    logic [MULT_W-1:0]          mult;
    logic [STEP_COUNT_BITS-1:0] decel;
    logic                       slot_free;
    logic                       in_acc;
    logic                       commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_time   <= TICK_RESET;
            r_ramp_enable <= 1'b0;
            r_ramp_inc    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TICK_TIME:   r_tick_time   <= i_cfg_data[TICK_W-1:0];
                CFG_RAMP_ENABLE: r_ramp_enable <= i_cfg_data[0];
                CFG_RAMP_INC:    r_ramp_inc    <= i_cfg_data[MULT_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_acc    = i_in_valid && o_in_ready;
    assign slot_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd       <= i_command;
            r_steps[0]  <= i_steps_x;
            r_steps[1]  <= i_steps_y;
            r_steps[2]  <= i_steps_z;
            r_period[0] <= i_period_x;
            r_period[1] <= i_period_y;
            r_period[2] <= i_period_z;
            r_dirs      <= i_move_dirs;
            r_decel_in  <= i_decel_steps;
            r_mult_in   <= i_start_multiplier;
            r_axis_in   <= i_lead_axis;
        end
    end

    // Tick delta: exact Q17.16 product when ramping, plain tick time otherwise.
    always_ff @(posedge i_clk) begin
        if (r_phase == PH_MUL) begin
            if (r_ramp_enable) begin
                r_dt <= DT_BITS'(r_tick_time) * DT_BITS'(mult);
            end else begin
                r_dt <= DT_BITS'({r_tick_time, {MULT_FRAC{1'b0}}});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE:  if (in_acc) n_phase = PH_MUL;
            PH_MUL:   n_phase = PH_ADD;
            PH_ADD:   n_phase = PH_CMP;
            PH_CMP:   n_phase = PH_MERGE;
            PH_MERGE: begin
                if (slot_free) begin
                    n_phase = in_acc ? PH_MUL : PH_IDLE;
                end
            end
            default:  n_phase = PH_IDLE;
        endcase
    end

    always_comb begin
        commit          = (r_phase == PH_MERGE) && slot_free;
        o_in_ready      = (r_phase == PH_IDLE) || commit;
        ctl.add_en      = (r_phase == PH_ADD);
        ctl.cmp_en      = (r_phase == PH_CMP);
        ctl.commit_tick = commit && (r_cmd != CMD_LOAD);
        ctl.commit_load = commit && (r_cmd == CMD_LOAD);
    end

    for (genvar a = 0; a < MAX_AXES; a++) begin : g_lane
        if (a < NUM_AXES) begin : g_on
            tasp_lane #(
                .STEP_COUNT_BITS (STEP_COUNT_BITS),
                .PERIOD_BITS     (PERIOD_BITS)
            ) u_lane (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (ctl),
                .i_dt          (r_dt),
                .i_decel       (decel),
                .i_load_steps  (r_steps[a]),
                .i_load_period (r_period[a]),
                .o_stat        (stat[a])
            );
        end else begin : g_off
            assign stat[a] = '0;
        end
    end

    tasp_merge #(
        .NUM_AXES        (NUM_AXES),
        .STEP_COUNT_BITS (STEP_COUNT_BITS)
    ) u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .i_stat           (stat),
        .i_ramp_enable    (r_ramp_enable),
        .i_ramp_inc       (r_ramp_inc),
        .i_load_dirs      (r_dirs),
        .i_load_decel     (r_decel_in),
        .i_load_mult      (r_mult_in),
        .i_load_axis      (r_axis_in),
        .i_out_ready      (i_out_ready),
        .o_mult           (mult),
        .o_decel          (decel),
        .o_out_valid      (o_out_valid),
        .o_step_pulses    (o_step_pulses),
        .o_dir_out        (o_dir_out),
        .o_busy_res       (o_busy_res),
        .o_multiplier_now (o_multiplier_now)
    );

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_phase == PH_MUL))
        else $error("accepted beat did not start the tick delta step");

    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_out_valid)
        else $error("committed beat left no result");

    a_mul_then_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MUL) |=> (r_phase == PH_ADD))
        else $error("sequencer skipped the accumulate step");

endmodule

>>> test/three_axis_step_pulse_generator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for three_axis_step_pulse_generator: directed and random
// load/tick beats, checked against a cycle-free motion predictor. Depends on tasp_pkg.
module three_axis_step_pulse_generator_tb;
    import tasp_pkg::*;

    localparam int STEP_BITS   = DEF_STEP_COUNT_BITS;
    localparam int PER_BITS    = DEF_PERIOD_BITS;
    localparam int CYCLE_LIMIT = 300000;

    localparam logic CMD_TICK = 1'b0;
    localparam logic [STEP_BITS-1:0] STEP_MAX   = '1;
    localparam logic [PER_BITS-1:0]  PERIOD_MAX = '1;

    // One input beat, laid out the way the driver applies it to the ports.
    typedef struct packed {
        logic                          cmd;
        logic [2:0][STEP_BITS-1:0]     steps;
        logic [2:0][PER_BITS-1:0]      period;
        logic [MAX_AXES-1:0]           dirs;
        logic [STEP_BITS-1:0]          decel;
        logic [MULT_W-1:0]             start_mult;
        logic [AXIS_W-1:0]             lead;
    } motion_beat_t;

    // A queued beat; drain_first makes the driver wait until every result is back.
    typedef struct packed {
        logic         drain_first;
        motion_beat_t beat;
    } pending_beat_t;

    typedef struct packed {
        logic [MAX_AXES-1:0] pulses;
        logic [MAX_AXES-1:0] dirs;
        logic                busy;
        logic [MULT_W-1:0]   mult;
    } step_report_t;

    // DUT connections. Every input starts at a known value.
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [MAX_AXES-1:0]        o_step_pulses;
    logic [MAX_AXES-1:0]        o_dir_out;
    logic                       o_busy_res;
    logic [MULT_W-1:0]          o_multiplier_now;
    motion_beat_t               cur_beat = '0;

    three_axis_step_pulse_generator #(
        .NUM_AXES        (DEF_NUM_AXES),
        .STEP_COUNT_BITS (STEP_BITS),
        .PERIOD_BITS     (PER_BITS)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (cur_beat.cmd),
        .i_steps_x          (cur_beat.steps[0]),
        .i_steps_y          (cur_beat.steps[1]),
        .i_steps_z          (cur_beat.steps[2]),
        .i_period_x         (cur_beat.period[0]),
        .i_period_y         (cur_beat.period[1]),
        .i_period_z         (cur_beat.period[2]),
        .i_move_dirs        (cur_beat.dirs),
        .i_decel_steps      (cur_beat.decel),
        .i_start_multiplier (cur_beat.start_mult),
        .i_lead_axis        (cur_beat.lead),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_step_pulses      (o_step_pulses),
        .o_dir_out          (o_dir_out),
        .o_busy_res         (o_busy_res),
        .o_multiplier_now   (o_multiplier_now)
    );

    // Predictor copy of the configuration registers, at their reset values.
    logic [TICK_W-1:0]          cfg_tick = TICK_RESET;
    logic                       cfg_ramp_on = 1'b0;
    logic [MULT_W-1:0]          cfg_ramp_inc = '0;

    // Predictor copy of the motion state, at its reset values.
    logic [STEP_BITS-1:0]       rem_count  [3] = '{default: '0};
    logic [PER_BITS-1:0]        phase_acc  [3] = '{default: '0};
    logic [PER_BITS-1:0]        period_reg [3] = '{default: '0};
    logic [MAX_AXES-1:0]        dir_bits = '0;
    logic [MULT_W-1:0]          mult_now = MULT_ONE;
    logic [STEP_BITS-1:0]       decel_level = '0;
    logic [AXIS_W-1:0]          lead_sel = '0;
    logic                       motion_on = 1'b0;

    pending_beat_t              pending_beats [$];
    step_report_t               predicted_reports [$];
    pending_beat_t              next_pending;
    step_report_t               want;

    // Handshake bookkeeping shared between the clock edges.
    bit                         beat_taken = 1'b0;
    int                         burst_left = 0;
    int                         gap_left = 0;
    bit                         hold_request = 1'b0;
    int                         hold_left = 0;
    int                         rx_cycles = 0;
    int                         rx_mode = 0;
    bit                         ready_next;

    int                         cycle_count = 0;
    int                         mismatches = 0;
    int                         beats_in = 0;
    int                         loads_in = 0;
    int                         results_seen = 0;
    int                         stepping_results = 0;
    int                         settings_used = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Prints one line per mismatch (the first fifty) and counts all of them.
    task automatic report_mismatch(input string what, input int beat_no,
                                   input logic [31:0] got, input logic [31:0] exp_val);
        if (mismatches < 50)
            $display("MISMATCH result %0d: %s got %h want %h", beat_no, what, got, exp_val);
        mismatches++;
    endtask

    // Applies one accepted beat to the predicted motion state and queues the
    // result that the block must produce for it.
    task automatic advance_motion(input motion_beat_t b);
        logic [MAX_AXES-1:0] pulses;
        logic [DT_BITS-1:0]  dt;
        logic [PER_BITS:0]   acc;
        int                  m;
        int                  inc;
        pulses = '0;
        if (b.cmd == CMD_LOAD) begin
            // A load replaces any move in progress and clears the accumulators.
            for (int a = 0; a < 3; a++) begin
                rem_count[a]  = b.steps[a];
                period_reg[a] = b.period[a];
                phase_acc[a]  = '0;
            end
            dir_bits    = b.dirs;
            decel_level = b.decel;
            mult_now    = (b.start_mult > MULT_ONE) ? MULT_ONE : b.start_mult;
            lead_sel    = b.lead;
            motion_on   = (rem_count[0] != 0) || (rem_count[1] != 0) || (rem_count[2] != 0);
        end else if (motion_on) begin
            // The delta is fixed for the whole tick, even if the ramp moves mid-tick.
            dt = cfg_ramp_on ? DT_BITS'(cfg_tick) * DT_BITS'(mult_now)
                             : DT_BITS'({cfg_tick, {MULT_FRAC{1'b0}}});
            for (int a = 0; a < 3; a++) begin
                if (rem_count[a] != 0) begin
                    acc = {1'b0, phase_acc[a]} + (PER_BITS + 1)'(dt);
                    if (acc > {1'b0, PERIOD_MAX})
                        acc = {1'b0, PERIOD_MAX};
                    if (acc >= {1'b0, period_reg[a]}) begin
                        acc = acc - {1'b0, period_reg[a]};
                        rem_count[a] = rem_count[a] - STEP_BITS'(1);
                        pulses[a] = 1'b1;
                        if (cfg_ramp_on && int'(lead_sel) == a) begin
                            // Lead-axis step: slow down inside the decel zone, not below
                            // the floor, and speed up elsewhere, not above 1.0.
                            m   = int'(mult_now);
                            inc = int'(cfg_ramp_inc);
                            if (rem_count[a] < decel_level) begin
                                if (m < inc + int'(MULT_FLOOR))
                                    m = int'(MULT_FLOOR);
                                else
                                    m = m - inc;
                            end else if (m < int'(MULT_ONE)) begin
                                m = m + inc;
                                if (m > int'(MULT_ONE))
                                    m = int'(MULT_ONE);
                            end
                            mult_now = MULT_W'(m);
                        end
                    end
                    phase_acc[a] = acc[PER_BITS-1:0];
                end
            end
            motion_on = (rem_count[0] != 0) || (rem_count[1] != 0) || (rem_count[2] != 0);
        end
        predicted_reports.push_back('{pulses: pulses, dirs: dir_bits, busy: motion_on,
                                      mult: mult_now});
    endtask

    // Input side, rising edge: a beat moves when valid and ready are both high.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            advance_motion(cur_beat);
            beat_taken = 1'b1;
            beats_in++;
            if (cur_beat.cmd == CMD_LOAD)
                loads_in++;
        end
    end

    // Input side, falling edge: offer the next beat in bursts with random gaps.
    // Valid is only lowered or replaced once the current beat has moved.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || beat_taken)) begin
            beat_taken = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_beats.size() != 0 &&
                         (!pending_beats[0].drain_first || predicted_reports.size() == 0)) begin
                next_pending = pending_beats.pop_front();
                cur_beat   <= next_pending.beat;
                i_in_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // Mostly short bursts, now and then a long stretch with no gaps.
                    burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side, falling edge: the receiver runs one of four stall patterns, picked
    // at random, and on request holds off for a long stretch of its own.
    always @(negedge i_clk) begin
        rx_cycles++;
        if (rx_cycles % 97 == 0)
            rx_mode = $urandom_range(0, 3);
        if (hold_left != 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 80;
            ready_next = 1'b0;
        end else begin
            case (rx_mode)
                0:       ready_next = 1'b1;
                1:       ready_next = 1'($urandom_range(0, 1));
                2:       ready_next = (rx_cycles % 5) >= 2;
                default: ready_next = ($urandom_range(0, 3) == 0);
            endcase
        end
        i_out_ready <= ready_next;
    end

    // Output side, rising edge: compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (predicted_reports.size() == 0) begin
                report_mismatch("result beat with nothing predicted", results_seen, 0, 0);
            end else begin
                want = predicted_reports.pop_front();
                if (want.pulses != 0)
                    stepping_results++;
                if (o_step_pulses !== want.pulses)
                    report_mismatch("step_pulses", results_seen, 32'(o_step_pulses),
                                    32'(want.pulses));
                if (o_dir_out !== want.dirs)
                    report_mismatch("dir_out", results_seen, 32'(o_dir_out), 32'(want.dirs));
                if (o_busy_res !== want.busy)
                    report_mismatch("busy_res", results_seen, 32'(o_busy_res),
                                    32'(want.busy));
                if (o_multiplier_now !== want.mult)
                    report_mismatch("multiplier_now", results_seen, 32'(o_multiplier_now),
                                    32'(want.mult));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due",
                     cycle_count, predicted_reports.size());
            $display("three_axis_step_pulse_generator_tb: errors");
            $finish;
        end
    end

    task automatic queue_beat(input motion_beat_t b, input logic drain_first);
        pending_beats.push_back('{drain_first: drain_first, beat: b});
    endtask

    // A tick carries random bits in the fields that only a load uses.
    function automatic motion_beat_t random_tick();
        motion_beat_t b;
        logic [255:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom};
        b = bits[$bits(motion_beat_t)-1:0];
        b.cmd = CMD_TICK;
        return b;
    endfunction

    function automatic motion_beat_t load_beat(
        input logic [STEP_BITS-1:0] sx, input logic [PER_BITS-1:0] px,
        input logic [STEP_BITS-1:0] sy, input logic [PER_BITS-1:0] py,
        input logic [STEP_BITS-1:0] sz, input logic [PER_BITS-1:0] pz,
        input logic [MAX_AXES-1:0] dirs, input logic [STEP_BITS-1:0] decel,
        input logic [MULT_W-1:0] mult, input logic [AXIS_W-1:0] lead);
        motion_beat_t b;
        b.cmd        = CMD_LOAD;
        b.steps      = {sz, sy, sx};
        b.period     = {pz, py, px};
        b.dirs       = dirs;
        b.decel      = decel;
        b.start_mult = mult;
        b.lead       = lead;
        return b;
    endfunction

    // Random load: mostly short moves whose periods are a few tick times long,
    // so that axes actually step; now and then full-width values.
    function automatic motion_beat_t random_load();
        motion_beat_t    b;
        logic [63:0]     wide;
        longint unsigned base;
        int              r;
        base = longint'(cfg_tick) << MULT_FRAC;
        b = '0;
        b.cmd = CMD_LOAD;
        for (int a = 0; a < 3; a++) begin
            r = $urandom_range(0, 9);
            if (r < 2)
                b.steps[a] = '0;
            else if (r < 8)
                b.steps[a] = STEP_BITS'($urandom_range(1, 12));
            else if (r == 8)
                b.steps[a] = STEP_BITS'($urandom_range(13, 300));
            else
                b.steps[a] = STEP_BITS'($urandom);
            wide = {$urandom, $urandom};
            r = $urandom_range(0, 9);
            if (r == 0)
                b.period[a] = '0;
            else if (r == 1)
                b.period[a] = wide[PER_BITS-1:0];
            else
                b.period[a] = PER_BITS'(base * $urandom_range(1, 24) / 8);
        end
        b.dirs = MAX_AXES'($urandom);
        r = $urandom_range(0, 5);
        b.decel = (r == 0) ? STEP_BITS'($urandom) : STEP_BITS'($urandom_range(0, 12));
        r = $urandom_range(0, 9);
        case (r)
            0:       b.start_mult = MULT_W'($urandom);
            1:       b.start_mult = '0;
            2:       b.start_mult = MULT_ONE;
            3:       b.start_mult = MULT_W'($urandom_range(65537, 131071));
            default: b.start_mult = MULT_W'($urandom_range(3000, 65536));
        endcase
        b.lead = AXIS_W'($urandom_range(0, 3));
        return b;
    endfunction

    // Returns at a rising edge once no beat is queued, offered or in flight.
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending_beats.size() != 0 || i_in_valid || predicted_reports.size() != 0)
            @(posedge i_clk);
    endtask

    // Writes all three registers; only called while the block is idle.
    task automatic set_regs(input logic [TICK_W-1:0] tk, input logic rmp,
                            input logic [MULT_W-1:0] inc);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TICK_TIME;
        i_cfg_data <= CFG_DATA_W'(tk);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_RAMP_ENABLE;
        i_cfg_data <= CFG_DATA_W'(rmp);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_RAMP_INC;
        i_cfg_data <= CFG_DATA_W'(inc);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_tick     = tk;
        cfg_ramp_on  = rmp;
        cfg_ramp_inc = inc;
        settings_used++;
    endtask

    initial begin
        int                ph;
        int                n;
        int                k;
        logic [TICK_W-1:0] tk;
        logic              rmp;
        logic [MULT_W-1:0] inc;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset configuration (tick 50, no ramp). Idle tick, an
        // all-zero move with saturating start multiplier, zero-period and
        // never-reached axes, then a load that lands while a move is running.
        queue_beat(random_tick(), 1'b0);
        queue_beat(load_beat('0, PERIOD_MAX, '0, PERIOD_MAX, '0, PERIOD_MAX, 3'b111,
                             STEP_MAX, 17'h1FFFF, 2'd3), 1'b0);
        queue_beat(random_tick(), 1'b0);
        queue_beat(load_beat(24'd3, '0, STEP_MAX, PERIOD_MAX, 24'd2, 40'd50 << 16,
                             3'b101, '0, '0, 2'd0), 1'b0);
        repeat (4) queue_beat(random_tick(), 1'b0);
        queue_beat(load_beat(24'd1, 40'd100 << 16, '0, '0, STEP_MAX, 40'd1, 3'b010,
                             24'd5, 17'd3276, 2'd2), 1'b0);
        repeat (2) queue_beat(random_tick(), 1'b0);
        wait_idle();

        // Directed, ramp on with the largest tick and an increment above 1.0:
        // the multiplier starts at zero, jumps to the ceiling, then drops to
        // the floor inside the deceleration zone. Then a lead axis that does
        // not exist, which leaves the multiplier alone.
        set_regs(16'hFFFF, 1'b1, 17'h1FFFF);
        queue_beat(load_beat(24'd4, '0, 24'd2, 40'hFF_FFFF_0000, 24'd1, PERIOD_MAX,
                             3'b011, 24'd2, '0, 2'd0), 1'b0);
        repeat (5) queue_beat(random_tick(), 1'b0);
        queue_beat(load_beat(24'd2, '0, '0, '0, '0, '0, 3'b001, STEP_MAX, 17'd40000,
                             2'd3), 1'b0);
        repeat (2) queue_beat(random_tick(), 1'b0);
        wait_idle();

        // Directed, zero tick time: only the zero-period axis can step.
        set_regs('0, 1'b1, 17'd1000);
        queue_beat(load_beat(24'd2, '0, 24'd2, 40'd1, '0, '0, 3'b100, '0, MULT_ONE,
                             2'd1), 1'b0);
        repeat (2) queue_beat(random_tick(), 1'b0);

        // Random phases, each under its own register setting. Most traffic is a
        // load followed by a run of ticks; the rest is stray ticks and loads
        // that cut a move short.
        for (ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0: begin tk = 16'd1; rmp = 1'b1; inc = '0; end
                1: begin tk = 16'hFFFF; rmp = 1'b0; inc = MULT_ONE; end
                2: begin
                    tk  = TICK_W'($urandom_range(1, 400));
                    rmp = 1'b1;
                    inc = MULT_W'($urandom_range(0, 5000));
                end
                3: begin
                    tk  = TICK_W'($urandom_range(1, 65535));
                    rmp = 1'b1;
                    inc = 17'h1FFFF;
                end
                4: begin
                    tk  = TICK_W'($urandom_range(1, 65535));
                    rmp = 1'b0;
                    inc = MULT_W'($urandom);
                end
                default: begin
                    tk  = TICK_W'($urandom_range(1, 2000));
                    rmp = 1'($urandom_range(0, 1));
                    inc = MULT_W'($urandom_range(0, 65536));
                end
            endcase
            set_regs(tk, rmp, inc);
            if (ph == 1) begin
                // One long move at the largest tick so that the accumulator of
                // a maximum-period axis runs into saturation and then steps.
                queue_beat(load_beat('0, '0, '0, '0, 24'd1, PERIOD_MAX, 3'b110, '0,
                                     MULT_ONE, 2'd2), 1'b0);
                repeat (260) queue_beat(random_tick(), 1'b0);
            end
            if (ph == 3)
                queue_beat(random_load(), 1'b1);
            n = 0;
            while (n < 100) begin
                if ($urandom_range(0, 9) == 0) begin
                    queue_beat(random_tick(), 1'b0);
                    n++;
                end else begin
                    queue_beat(random_load(), $urandom_range(0, 40) == 0);
                    k = $urandom_range(2, 25);
                    repeat (k) queue_beat(random_tick(), $urandom_range(0, 60) == 0);
                    n += k + 1;
                end
            end
            // Long receiver hold-off while the sender keeps offering beats.
            if (ph == 2)
                hold_request = 1'b1;
        end

        wait_idle();
        // Let a stray result, if any, show up before the verdict.
        repeat (12) @(posedge i_clk);

        $display("Covered %0d beats (%0d loads), %0d results checked, %0d with steps,",
                 beats_in, loads_in, results_seen, stepping_results);
        $display("under %0d register settings plus reset defaults; %0d mismatches",
                 settings_used, mismatches);
        if (mismatches == 0)
            $display("three_axis_step_pulse_generator_tb: clean");
        else
            $display("three_axis_step_pulse_generator_tb: errors");
        $finish;
    end

endmodule
